/* rtl/anbs_pkg.sv */
// shared types and constants of the annex b nal unit splitter
package anbs_pkg;

	localparam int MaxResults = 5;
	localparam int CntW       = $clog2(MaxResults + 1);
	localparam int QDepth     = 4;
	localparam int QPtrW      = $clog2(QDepth);
	localparam int QCntW      = $clog2(QDepth + 1);

	localparam logic [7:0] ByteZero   = 8'h00;
	localparam logic [7:0] ByteOne    = 8'h01;
	localparam logic [4:0] NalTypeAud = 5'h09;
	localparam logic [1:0] ZeroRunMax = 2'd3;
	localparam logic [1:0] ZeroRunSc  = 2'd2;

	// one result item
	typedef struct packed {
		logic [7:0] unit_byte;
		logic [4:0] unit_type;
		logic       first_of_unit;
		logic       last_of_unit;
	} item_t;

	// all result items caused by one input byte
	typedef struct packed {
		logic [CntW-1:0]            count;
		item_t [MaxResults-1:0]     items;
	} batch_t;

	// front to queue
	typedef struct packed {
		logic   push;
		batch_t batch;
	} push_t;

	// queue to back
	typedef struct packed {
		logic   valid;
		batch_t head;
	} head_t;

endpackage

/* rtl/anbs_front.sv */
// front part: start code scan, unit tracking and result batch build
module anbs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_full,
	input  logic [7:0]     stream_byte,
	input  logic           end_of_stream,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic           drop_delimiters,
	output anbs_pkg::push_t push_o
);
	import anbs_pkg::*;

	typedef struct packed {
		logic [1:0] zero_run;
		logic [7:0] held_byte;
		logic       held_valid;
		logic       in_unit;
		logic       header_pending;
		logic [4:0] current_type;
		logic       dropping;
		logic       first_pending;
	} state_t;

	typedef struct packed {
		state_t st;
		logic   emit;
		item_t  item;
	} step_t;

	state_t state_q;
	logic   drop_q;
	state_t st_n;
	batch_t batch;
	logic   accept;

	// push a byte into the unit, releasing the held one
	function automatic step_t do_commit(state_t s, logic [7:0] x, logic drop);
		step_t r;
		r.st   = s;
		r.emit = 1'b0;
		r.item = '0;
		if (s.in_unit) begin
			if (r.st.header_pending) begin
				r.st.current_type   = x[4:0];
				r.st.dropping       = drop && (x[4:0] == NalTypeAud);
				r.st.header_pending = 1'b0;
				r.st.first_pending  = !r.st.dropping;
			end
			if (!r.st.dropping) begin
				if (r.st.held_valid) begin
					r.emit = 1'b1;
					r.item = '{unit_byte: r.st.held_byte, unit_type: r.st.current_type,
						first_of_unit: r.st.first_pending, last_of_unit: 1'b0};
					r.st.first_pending = 1'b0;
				end
				r.st.held_byte  = x;
				r.st.held_valid = 1'b1;
			end
		end
		return r;
	endfunction

	// give out the held byte as the unit's final byte
	function automatic step_t do_release(state_t s);
		step_t r;
		r.st   = s;
		r.emit = 1'b0;
		r.item = '0;
		if (s.held_valid) begin
			r.emit = 1'b1;
			r.item = '{unit_byte: s.held_byte, unit_type: s.current_type,
				first_of_unit: s.first_pending, last_of_unit: 1'b1};
			r.st.first_pending = 1'b0;
			r.st.held_valid    = 1'b0;
		end
		return r;
	endfunction

	function automatic batch_t do_append(batch_t b, step_t r);
		batch_t o;
		o = b;
		if (r.emit) begin
			o.items[b.count] = r.item;
			o.count          = b.count + CntW'(1);
		end
		return o;
	endfunction

	always_comb begin
		state_t     s;
		step_t      r;
		logic [1:0] zr;
		s     = state_q;
		r     = '0;
		zr    = '0;
		batch = '0;
		if (stream_byte == ByteZero) begin
			if (s.zero_run != ZeroRunMax) begin
				s.zero_run = s.zero_run + 2'd1;
			end else begin
				r     = do_commit(s, ByteZero, drop_q);
				s     = r.st;
				batch = do_append(batch, r);
			end
		end else if (stream_byte == ByteOne && s.zero_run >= ZeroRunSc) begin
			r                = do_release(s);
			s                = r.st;
			batch            = do_append(batch, r);
			s.in_unit        = 1'b1;
			s.header_pending = 1'b1;
			s.dropping       = 1'b0;
			s.first_pending  = 1'b0;
			s.zero_run       = '0;
		end else begin
			// held zeros were not a start code: they belong to the unit
			zr = s.zero_run;
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < zr) begin
					r     = do_commit(s, ByteZero, drop_q);
					s     = r.st;
					batch = do_append(batch, r);
				end
			end
			s.zero_run = '0;
			r     = do_commit(s, stream_byte, drop_q);
			s     = r.st;
			batch = do_append(batch, r);
		end
		if (end_of_stream) begin
			zr = s.zero_run;
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < zr) begin
					r     = do_commit(s, ByteZero, drop_q);
					s     = r.st;
					batch = do_append(batch, r);
				end
			end
			s.zero_run = '0;
			r     = do_release(s);
			batch = do_append(batch, r);
			s     = '0;
		end
		st_n = s;
	end

	assign accept       = in_valid && !in_full;
	assign push_o.push  = accept && (batch.count != '0);
	assign push_o.batch = batch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			drop_q  <= 1'b1;
		end else begin
			if (accept) begin
				state_q <= st_n;
			end
			if (cfg_valid && cfg_ready) begin
				drop_q <= drop_delimiters;
			end
		end
	end

endmodule

/* rtl/anbs_queue.sv */
// short queue of result batches between front and back
module anbs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  anbs_pkg::push_t push_i,
	input  logic            pop,
	output anbs_pkg::head_t head_o,
	output logic            full
);
	import anbs_pkg::*;

	batch_t           mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full         = (count_q == QCntW'(QDepth));
	assign head_o.valid = (count_q != '0);
	assign head_o.head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_i.push) begin
			mem_q[wr_ptr_q] <= push_i.batch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_i.push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (push_i.push && !pop) begin
				count_q <= count_q + QCntW'(1);
			end else if (pop && !push_i.push) begin
				count_q <= count_q - QCntW'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_i.push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_o.valid) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth)) else $error("queue count out of range");
	a_nonempty_batch: assert property (@(posedge clk) disable iff (!arst_n)
		push_i.push |-> (push_i.batch.count != '0 && push_i.batch.count <= CntW'(MaxResults)))
		else $error("bad batch size pushed");

endmodule

/* rtl/anbs_back.sv */
// back part: hands out the items of each batch one per cycle while out_stall is low
module anbs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  anbs_pkg::head_t head_i,
	output logic            pop,
	input  logic            out_stall,
	output logic            out_valid,
	output anbs_pkg::item_t item_o
);
	import anbs_pkg::*;

	logic [CntW-1:0] idx_q;
	logic            out_valid_q;
	item_t           item_q;
	logic            load;
	logic            last_item;

	assign load      = head_i.valid && (!out_valid_q || !out_stall);
	assign last_item = (idx_q == head_i.head.count - CntW'(1));
	assign pop       = load && last_item;
	assign out_valid = out_valid_q;
	assign item_o    = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_item ? '0 : idx_q + CntW'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= head_i.head.items[idx_q];
		end
	end

	a_idx_in_batch: assert property (@(posedge clk) disable iff (!arst_n)
		head_i.valid |-> idx_q < head_i.head.count) else $error("item index past batch");
	a_idx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!head_i.valid |-> idx_q == '0) else $error("item index left over");

endmodule

/* rtl/annexb_nal_unit_splitter.sv */
// top level of the annex b byte stream nal unit splitter
// usage:
//   input channel (in_valid / in_stall) takes one stream byte per transfer with an
//   end_of_stream mark on the last byte; output channel (out_valid / out_stall)
//   gives one nal unit byte per transfer with its unit type and first/last marks
//   config channel (cfg_valid / cfg_ready) writes drop_delimiters; always ready,
//   write it only while the block is idle
// path: a byte's batch is written into the queue at the input transfer edge, and
//   its first result then passes the back output register on its way to the output
// throughput: one input byte per cycle while the queue has room; the back side
//   hands out one item per cycle while out_stall is low, so the up to five items
//   that one byte can release (zeros that turned out not to be a start code, plus
//   end of stream) leave one by one; the four-entry batch queue absorbs such bursts
// in_stall rises only when the batch queue is full; it never waits on in_valid
// a stalled output keeps its item; the front keeps taking bytes until the queue fills
// reset: stream state clears (no open unit, bytes discarded until a start code),
//   queue empties, drop_delimiters returns to 1
// end of stream flushes held zeros and the held byte, then the stream state clears
module annexb_nal_unit_splitter (
	input  logic       clk,
	input  logic       arst_n,
	// byte stream in
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] stream_byte,
	input  logic       end_of_stream,
	// nal unit bytes out
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] unit_byte,
	output logic [4:0] unit_type,
	output logic       first_of_unit,
	output logic       last_of_unit,
	// configuration write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       drop_delimiters
);
	import anbs_pkg::*;

	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;
	item_t item;

	// register write is never held off: the channel is always ready
	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	// front: start code detection and batch build per accepted byte
	anbs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_full        (q_full),
		.stream_byte    (stream_byte),
		.end_of_stream  (end_of_stream),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.drop_delimiters(drop_delimiters),
		.push_o         (push)
	);

	// decouples byte intake from item output
	anbs_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push_i(push),
		.pop   (pop),
		.head_o(head),
		.full  (q_full)
	);

	// back: one item per transfer from the head batch
	anbs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_i   (head),
		.pop      (pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.item_o   (item)
	);

	assign unit_byte     = item.unit_byte;
	assign unit_type     = item.unit_type;
	assign first_of_unit = item.first_of_unit;
	assign last_of_unit  = item.last_of_unit;

endmodule

/* verif/tb.sv */
// self-checking testbench for the annex b nal unit splitter
`timescale 1ns / 100ps

module tb;

	import anbs_pkg::*;

	localparam int unsigned SettleCycles = 8;      // output path latency plus margin
	localparam int unsigned HoldCycles   = 90;     // long receiver hold, fills the batch queue
	localparam int unsigned PhaseBytes   = 46;     // random stream bytes per phase
	localparam int unsigned NumPhases    = 4;
	localparam int unsigned TimeoutNs    = 1_000_000;

	// one stream byte as offered on the input channel
	typedef struct packed {
		logic [7:0] sb;
		logic       eos;
	} stream_in_t;

	// directed row: stimulus, plus a typed expectation where the outcome is plain
	typedef struct {
		logic [7:0]  sb;
		logic        eos;
		bit          typed;
		int unsigned n_out;
		logic [7:0]  want_byte;
		logic [4:0]  want_type;
		logic        want_first;
		logic        want_last;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] stream_byte;
	logic       end_of_stream;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] unit_byte;
	logic [4:0] unit_type;
	logic       first_of_unit;
	logic       last_of_unit;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       drop_delimiters;

	// nal unit bytes still owed by the block, oldest first
	item_t      nal_bytes_due[$];
	// bytes released by the stream byte just parsed
	item_t      released_bytes[$];
	stream_in_t phase_bytes[$];

	int unsigned error_count    = 0;
	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_request   = 1'b0;

	// mirror of the splitter state
	logic       drop_aud;
	logic [1:0] zeros_held;
	logic [7:0] held_b;
	logic       held_ok;
	logic       unit_open;
	logic       header_next;
	logic [4:0] open_type;
	logic       skipping;
	logic       header_held;

	// directed stream, walked in order right after reset with drop_delimiters at 1
	dir_row_t dir_rows [28] = '{
		// garbage before any start code, end of stream on it: nothing comes out
		'{8'hFF, 1'b1, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		// three-byte start code
		'{8'h00, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h01, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		// header with forbidden bit and ref idc set, type 5, held back
		'{8'hE5, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		// next byte pushes the header out
		'{8'hFF, 1'b0, 1'b1, 1, 8'hE5, 5'd5, 1'b1, 1'b0},
		// four zeros then 0x01: the extra zero stays in the unit
		'{8'h00, 1'b0, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		// access unit delimiter, dropped whole
		'{8'h09, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h01, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		// start code right after a start code: empty unit
		'{8'h00, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h01, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		// type 1 unit, two zeros that turn out to be data, then end of stream
		'{8'h41, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h7F, 1'b1, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		// fresh stream, unit ends in an unfinished start code at end of stream
		'{8'h00, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h01, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h65, 1'b0, 1'b1, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 0, 8'h00, 5'd0, 1'b0, 1'b0}
	};

	annexb_nal_unit_splitter DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.stream_byte     (stream_byte),
		.end_of_stream   (end_of_stream),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.unit_byte       (unit_byte),
		.unit_type       (unit_type),
		.first_of_unit   (first_of_unit),
		.last_of_unit    (last_of_unit),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.drop_delimiters (drop_delimiters)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function void clear_stream_state();
		zeros_held  = '0;
		held_b      = '0;
		held_ok     = 1'b0;
		unit_open   = 1'b0;
		header_next = 1'b0;
		open_type   = '0;
		skipping    = 1'b0;
		header_held = 1'b0;
	endfunction

	function void put_unit_byte(logic [7:0] b, logic first, logic last);
		if (released_bytes.size() < MaxResults)
			released_bytes.push_back({b, open_type, first, last});
	endfunction

	// the byte held back goes out once we know whether it ends its unit
	function void flush_held(logic last);
		if (held_ok) begin
			put_unit_byte(held_b, header_held, last);
			header_held = 1'b0;
			held_ok     = 1'b0;
		end
	endfunction

	// a byte that belongs to the open unit (if any)
	function void take_byte(logic [7:0] x);
		if (!unit_open)
			return;
		if (header_next) begin
			// drop_delimiters is sampled here, on the header byte only
			open_type   = x[4:0];
			skipping    = drop_aud && (open_type == NalTypeAud);
			header_next = 1'b0;
			header_held = !skipping;
		end
		if (skipping)
			return;
		flush_held(1'b0);
		held_b  = x;
		held_ok = 1'b1;
	endfunction

	// zeros held as a possible start code turn out to be data
	function void flush_zeros();
		while (zeros_held != 0) begin
			take_byte(ByteZero);
			zeros_held--;
		end
	endfunction

	function void parse_stream_byte(logic [7:0] b, logic eos);
		released_bytes.delete();
		if (b == ByteZero) begin
			// beyond three zeros, the oldest one is data of the previous unit
			if (zeros_held < ZeroRunMax)
				zeros_held++;
			else
				take_byte(ByteZero);
		end else if (b == ByteOne && zeros_held >= ZeroRunSc) begin
			// start code: close the open unit, next byte is a header
			flush_held(1'b1);
			unit_open   = 1'b1;
			header_next = 1'b1;
			skipping    = 1'b0;
			header_held = 1'b0;
			zeros_held  = '0;
		end else begin
			flush_zeros();
			take_byte(b);
		end
		if (eos) begin
			flush_zeros();
			flush_held(1'b1);
			clear_stream_state();
		end
	endfunction

	function void queue_released();
		foreach (released_bytes[k])
			nal_bytes_due.push_back(released_bytes[k]);
	endfunction

	// ---------------------------------------------------------------- stimulus

	// idle stretch length: usually from the short range, now and then from the long one
	function int unsigned idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function void add_byte(logic [7:0] b);
		phase_bytes.push_back({b, 1'b0});
	endfunction

	// payload leans on zeros and ones so that near-miss start codes show up
	function logic [7:0] payload_byte();
		case ($urandom_range(0, 9))
			0, 1:    return ByteZero;
			2:       return ByteOne;
			3:       return 8'h03;
			4:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly well-formed units with random content, some noise and broken codes
	function void build_phase(int unsigned n_bytes);
		int unsigned kind;
		int unsigned n_zero;
		logic [7:0]  hdr;
		phase_bytes.delete();
		while (phase_bytes.size() < n_bytes) begin
			kind = $urandom_range(0, 99);
			if (kind < 80) begin
				// three- or four-byte start code, sometimes with extra zeros in front
				n_zero = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3);
				repeat (n_zero) add_byte(ByteZero);
				add_byte(ByteOne);
				// a few units are left empty
				if ($urandom_range(0, 9) != 0) begin
					hdr = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 3) == 0)
						hdr[4:0] = NalTypeAud;
					add_byte(hdr);
					repeat ($urandom_range(0, 6)) add_byte(payload_byte());
				end
			end else if (kind < 90) begin
				repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						add_byte(ByteZero);
						add_byte(ByteZero);
						add_byte(8'h02);
					end
					1: begin
						add_byte(ByteZero);
						add_byte(ByteOne);
					end
					default: repeat (6) add_byte(ByteZero);
				endcase
			end
			// end of stream on whatever byte closes this piece
			if ($urandom_range(0, 9) == 0)
				phase_bytes[phase_bytes.size() - 1].eos = 1'b1;
		end
	endfunction

	// one input transfer, with an optional gap before it; entered right after an edge
	task send_byte(logic [7:0] b, logic eos);
		if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		in_valid      <= 1'b1;
		stream_byte   <= b;
		end_of_stream <= eos;
		do
			@(posedge clk);
		while (in_stall);
		parse_stream_byte(b, eos);
	endtask

	// sender pauses until every owed byte is out, then lets the pipeline drain
	task wait_idle();
		in_valid <= 1'b0;
		while (nal_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task load_drop_delimiters(logic v);
		cfg_valid       <= 1'b1;
		drop_delimiters <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		drop_aud = v;
	endtask

	// ---------------------------------------------------------------- receiver

	// random output stalls, plus one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < recv_stall_pct) begin
				out_stall <= 1'b1;
				repeat (idle_len()) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			error_count++;
		end
	endfunction

	// every output transfer is matched against the oldest owed byte
	always @(posedge clk) begin
		item_t want;
		if (out_valid && !out_stall) begin
			if (nal_bytes_due.size() == 0) begin
				$display("%0t: unexpected unit byte %02h type %0d", $time, unit_byte, unit_type);
				error_count++;
			end else begin
				want = nal_bytes_due.pop_front();
				check_field("unit_byte", want.unit_byte, unit_byte);
				check_field("unit_type", want.unit_type, unit_type);
				check_field("first_of_unit", want.first_of_unit, first_of_unit);
				check_field("last_of_unit", want.last_of_unit, last_of_unit);
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		stream_byte     = '0;
		end_of_stream   = 1'b0;
		cfg_valid       = 1'b0;
		drop_delimiters = 1'b1;
		clear_stream_state();
		drop_aud = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value written back explicitly, then the directed stream
		load_drop_delimiters(1'b1);
		send_gap_pct   = 10;
		recv_stall_pct = 10;
		foreach (dir_rows[r]) begin
			send_byte(dir_rows[r].sb, dir_rows[r].eos);
			if (!dir_rows[r].typed)
				queue_released();
			else if (dir_rows[r].n_out == 1)
				nal_bytes_due.push_back({dir_rows[r].want_byte, dir_rows[r].want_type,
					dir_rows[r].want_first, dir_rows[r].want_last});
		end

		// random phases, drop_delimiters alternating 0 and 1
		for (int p = 0; p < NumPhases; p++) begin
			wait_idle();
			load_drop_delimiters(p[0]);
			case (p)
				0: begin
					send_gap_pct   = 20;
					recv_stall_pct = 20;
				end
				1: begin
					// receiver holds off while the sender keeps offering back to back
					send_gap_pct   = 0;
					recv_stall_pct = 15;
					hold_request   = 1'b1;
				end
				2: begin
					// full rate both ways
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
				default: begin
					send_gap_pct   = 30;
					recv_stall_pct = 30;
				end
			endcase
			build_phase(PhaseBytes);
			foreach (phase_bytes[i]) begin
				// halfway through the last phase the sender waits for the block to drain
				if (p == NumPhases - 1 && i == phase_bytes.size() / 2)
					wait_idle();
				send_byte(phase_bytes[i].sb, phase_bytes[i].eos);
				queue_released();
			end
		end

		wait_idle();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(TimeoutNs);
		$display("simulation failed");
		$finish;
	end

endmodule
